@@ rtl/tcm_pkg.sv @@
// Shared constants and types for the touch coordinate mapper.
package tcm_pkg;

    localparam int PORTRAIT_WIDTH  = 1072;
    localparam int PORTRAIT_HEIGHT = 1448;

    localparam int RAW_W   = 16;
    localparam int COORD_W = 11;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam int EXT_MAX = (PORTRAIT_WIDTH > PORTRAIT_HEIGHT) ? PORTRAIT_WIDTH
                                                                : PORTRAIT_HEIGHT;
    localparam int QW      = $clog2(EXT_MAX);
    localparam int PROD_W  = RAW_W + QW;

    localparam logic [QW-1:0] WIDTH_M1  = QW'(PORTRAIT_WIDTH - 1);
    localparam logic [QW-1:0] HEIGHT_M1 = QW'(PORTRAIT_HEIGHT - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_RAW_MIN = 3'd0,
        REG_X_RAW_MAX = 3'd1,
        REG_Y_RAW_MIN = 3'd2,
        REG_Y_RAW_MAX = 3'd3,
        REG_SWAP_AXES = 3'd4,
        REG_INVERT_X  = 3'd5,
        REG_INVERT_Y  = 3'd6,
        REG_ROTATION  = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ROT_PORTRAIT = 2'd0,
        ROT_CW       = 2'd1,
        ROT_INVERTED = 2'd2,
        ROT_CCW      = 2'd3
    } rot_t;

endpackage

@@ rtl/touch_coordinate_mapper.sv @@
// Touch coordinate mapper: clamp, scale, swap, invert and rotate raw touch samples.
//
// Usage:
//   Slave stream s_*: one beat per raw sample, tdata = {raw_y, raw_x}.
//   Master stream m_*: one beat per mapped point, tdata = {screen_y, screen_x},
//   tuser = mapped_ok. Every input beat gives exactly one output beat.
//   Configuration: cfg_wr_en with cfg_index / cfg_data writes one register in
//   the cycle it is high; write only while no beat is in flight.
// Pipeline: one clamp stage, one multiply stage, one restoring-divide stage per
//   quotient bit, one invert/rotate stage that is also the output register.
// Throughput: one beat per cycle while the output is not stalled; the divider is
//   fully pipelined, one quotient bit per stage for each axis.
// Reset: all stages empty, calibration back to 0..4095 on both axes, no swap,
//   no inversion, portrait rotation.
// Stall: while m_tready is low and a beat waits, the whole pipeline holds and
//   s_tready drops; nothing is dropped or repeated. Bubbles are filled
//   as long as the output register is free.
module touch_coordinate_mapper
    import tcm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // [15:0] raw_x, [31:16] raw_y

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // [10:0] screen_x, [21:11] screen_y, [23:22] zero
    output logic [0:0]           m_tuser,   // [0] mapped_ok

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Configuration registers
    logic [RAW_W-1:0] x_min_reg, x_max_reg, y_min_reg, y_max_reg;
    logic             swap_reg, inv_x_reg, inv_y_reg;
    logic [1:0]       rot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg <= '0;
            x_max_reg <= RAW_W'(4095);
            y_min_reg <= '0;
            y_max_reg <= RAW_W'(4095);
            swap_reg  <= 1'b0;
            inv_x_reg <= 1'b0;
            inv_y_reg <= 1'b0;
            rot_reg   <= ROT_PORTRAIT;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_X_RAW_MIN: x_min_reg <= cfg_data[RAW_W-1:0];
                REG_X_RAW_MAX: x_max_reg <= cfg_data[RAW_W-1:0];
                REG_Y_RAW_MIN: y_min_reg <= cfg_data[RAW_W-1:0];
                REG_Y_RAW_MAX: y_max_reg <= cfg_data[RAW_W-1:0];
                REG_SWAP_AXES: swap_reg  <= cfg_data[0];
                REG_INVERT_X:  inv_x_reg <= cfg_data[0];
                REG_INVERT_Y:  inv_y_reg <= cfg_data[0];
                REG_ROTATION:  rot_reg   <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic advance;
    logic out_valid_reg;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;

    // Stage 1: swap, clamp, offset. Axis 0 is portrait X, axis 1 portrait Y.
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_ok_reg, s1_ok_next;
    logic [RAW_W-1:0] s1_diff_reg [2];
    logic [RAW_W-1:0] s1_diff_next [2];
    logic [RAW_W-1:0] s1_den_reg [2];
    logic [RAW_W-1:0] s1_den_next [2];

    logic [RAW_W-1:0] raw_x, raw_y;
    logic [RAW_W-1:0] ax_val [2];
    logic [RAW_W-1:0] ax_lo [2];
    logic [RAW_W-1:0] ax_hi [2];
    logic [RAW_W-1:0] ax_clamp [2];

    assign raw_x = s_tdata[RAW_W-1:0];
    assign raw_y = s_tdata[2*RAW_W-1:RAW_W];

    always_comb
    begin
        ax_val[0] = swap_reg ? raw_y     : raw_x;
        ax_lo[0]  = swap_reg ? y_min_reg : x_min_reg;
        ax_hi[0]  = swap_reg ? y_max_reg : x_max_reg;
        ax_val[1] = swap_reg ? raw_x     : raw_y;
        ax_lo[1]  = swap_reg ? x_min_reg : y_min_reg;
        ax_hi[1]  = swap_reg ? x_max_reg : y_max_reg;
        for (int j = 0; j < 2; j++)
        begin
            if (ax_val[j] < ax_lo[j])
                ax_clamp[j] = ax_lo[j];
            else if (ax_val[j] > ax_hi[j])
                ax_clamp[j] = ax_hi[j];
            else
                ax_clamp[j] = ax_val[j];
            s1_diff_next[j] = ax_clamp[j] - ax_lo[j];
            s1_den_next[j]  = ax_hi[j] - ax_lo[j];
        end
        s1_ok_next    = (x_max_reg > x_min_reg) && (y_max_reg > y_min_reg);
        s1_valid_next = s_tvalid;
    end

    // Stage 2 (divide stage 0): multiply by extent - 1
    // Divide stage k holds the item after k quotient bits.
    logic              dv_valid_reg [QW+1];
    logic              dv_valid_next [QW+1];
    logic              dv_ok_reg [QW+1];
    logic              dv_ok_next [QW+1];
    logic [PROD_W-1:0] dv_num_reg [QW+1][2];
    logic [PROD_W-1:0] dv_num_next [QW+1][2];
    logic [RAW_W-1:0]  dv_rem_reg [QW+1][2];
    logic [RAW_W-1:0]  dv_rem_next [QW+1][2];
    logic [RAW_W-1:0]  dv_den_reg [QW+1][2];
    logic [RAW_W-1:0]  dv_den_next [QW+1][2];
    logic [QW-1:0]     dv_quo_reg [QW+1][2];
    logic [QW-1:0]     dv_quo_next [QW+1][2];

    logic [QW-1:0]     ext_m1 [2];
    logic [PROD_W-1:0] prod [2];
    logic [RAW_W:0]    trial [QW][2];
    logic              ge [QW][2];

    always_comb
    begin
        ext_m1[0] = WIDTH_M1;
        ext_m1[1] = HEIGHT_M1;
        dv_valid_next[0] = s1_valid_reg;
        dv_ok_next[0]    = s1_ok_reg;
        for (int j = 0; j < 2; j++)
        begin
            prod[j] = PROD_W'(s1_diff_reg[j]) * PROD_W'(ext_m1[j]);
            dv_num_next[0][j] = prod[j];
            dv_rem_next[0][j] = prod[j][PROD_W-1:QW];
            dv_den_next[0][j] = s1_den_reg[j];
            dv_quo_next[0][j] = '0;
        end
        for (int k = 0; k < QW; k++)
        begin
            dv_valid_next[k+1] = dv_valid_reg[k];
            dv_ok_next[k+1]    = dv_ok_reg[k];
            for (int j = 0; j < 2; j++)
            begin
                trial[k][j] = {dv_rem_reg[k][j], dv_num_reg[k][j][QW-1-k]};
                ge[k][j]    = trial[k][j] >= {1'b0, dv_den_reg[k][j]};
                dv_rem_next[k+1][j] = ge[k][j]
                                    ? RAW_W'(trial[k][j] - {1'b0, dv_den_reg[k][j]})
                                    : trial[k][j][RAW_W-1:0];
                dv_quo_next[k+1][j] = QW'({dv_quo_reg[k][j], ge[k][j]});
                dv_num_next[k+1][j] = dv_num_reg[k][j];
                dv_den_next[k+1][j] = dv_den_reg[k][j];
            end
        end
    end

    // Output stage: invert, rotate, mask
    logic               out_valid_next;
    logic               out_ok_reg, out_ok_next;
    logic [COORD_W-1:0] out_x_reg, out_x_next;
    logic [COORD_W-1:0] out_y_reg, out_y_next;
    logic [QW-1:0]      px, py, sx, sy;

    always_comb
    begin
        px = dv_quo_reg[QW][0];
        py = dv_quo_reg[QW][1];
        if (inv_x_reg)
            px = WIDTH_M1 - px;
        if (inv_y_reg)
            py = HEIGHT_M1 - py;
        unique case (rot_t'(rot_reg))
            ROT_PORTRAIT:
            begin
                sx = px;
                sy = py;
            end
            ROT_CW:
            begin
                sx = HEIGHT_M1 - py;
                sy = px;
            end
            ROT_INVERTED:
            begin
                sx = WIDTH_M1 - px;
                sy = HEIGHT_M1 - py;
            end
            default:
            begin
                sx = py;
                sy = WIDTH_M1 - px;
            end
        endcase
        out_valid_next = dv_valid_reg[QW];
        out_ok_next    = dv_ok_reg[QW];
        out_x_next     = dv_ok_reg[QW] ? COORD_W'(sx) : '0;
        out_y_next     = dv_ok_reg[QW] ? COORD_W'(sy) : '0;
    end

    // Control: valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= QW; k++)
                dv_valid_reg[k] <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            for (int k = 0; k <= QW; k++)
                dv_valid_reg[k] <= dv_valid_next[k];
        end
    end

    // Payload: hold on stall
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_ok_reg  <= s1_ok_next;
            out_ok_reg <= out_ok_next;
            out_x_reg  <= out_x_next;
            out_y_reg  <= out_y_next;
            for (int j = 0; j < 2; j++)
            begin
                s1_diff_reg[j] <= s1_diff_next[j];
                s1_den_reg[j]  <= s1_den_next[j];
            end
            for (int k = 0; k <= QW; k++)
            begin
                dv_ok_reg[k] <= dv_ok_next[k];
                for (int j = 0; j < 2; j++)
                begin
                    dv_num_reg[k][j] <= dv_num_next[k][j];
                    dv_rem_reg[k][j] <= dv_rem_next[k][j];
                    dv_den_reg[k][j] <= dv_den_next[k][j];
                    dv_quo_reg[k][j] <= dv_quo_next[k][j];
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_y_reg, out_x_reg};
    assign m_tuser  = out_ok_reg;

endmodule

@@ bench/tb_touch_coordinate_mapper.sv @@
// Self-checking stream testbench for touch_coordinate_mapper: calibration, swap, invert, rotate.
`timescale 1ns / 100ps

module tb_touch_coordinate_mapper
    import tcm_pkg::*;
;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN       = 2 * (QW + 3);
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic               ok;
    } point_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;    // [15:0] raw_x, [31:16] raw_y
    logic                 m_tvalid;
    logic                 m_tready;
    logic [23:0]          m_tdata;    // [10:0] screen_x, [21:11] screen_y, [23:22] zero
    logic [0:0]           m_tuser;    // [0] mapped_ok
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    logic [31:0]  raw_pending[$];
    point_t       points_due[$];
    point_t       want_pt;
    int           errors = 0;
    int           cycle_count = 0;
    bit           steady = 1'b0;
    logic         hold_kick = 1'b0;
    logic         hold_seen;
    int           hold_left;

    logic [15:0]  cal_x_lo, cal_x_hi, cal_y_lo, cal_y_hi;
    logic         swap_xy, mirror_x, mirror_y;
    rot_t         rot_sel;

    touch_coordinate_mapper dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned scale_axis(logic [15:0] v, logic [15:0] lo,
                                               logic [15:0] hi, int unsigned extent);
        longint unsigned c;
        c = 64'(v);
        if (c < lo)
            c = 64'(lo);
        if (c > hi)
            c = 64'(hi);
        return 32'((c - lo) * (extent - 1) / (hi - lo));
    endfunction

    function automatic point_t map_point(logic [15:0] rx, logic [15:0] ry);
        point_t      p;
        int unsigned px, py, sx, sy;
        p = '0;
        if (cal_x_hi <= cal_x_lo || cal_y_hi <= cal_y_lo)
            return p;
        if (swap_xy)
        begin
            px = scale_axis(ry, cal_y_lo, cal_y_hi, PORTRAIT_WIDTH);
            py = scale_axis(rx, cal_x_lo, cal_x_hi, PORTRAIT_HEIGHT);
        end
        else
        begin
            px = scale_axis(rx, cal_x_lo, cal_x_hi, PORTRAIT_WIDTH);
            py = scale_axis(ry, cal_y_lo, cal_y_hi, PORTRAIT_HEIGHT);
        end
        if (mirror_x)
            px = PORTRAIT_WIDTH - 1 - px;
        if (mirror_y)
            py = PORTRAIT_HEIGHT - 1 - py;
        case (rot_sel)
            ROT_PORTRAIT:
            begin
                sx = px;
                sy = py;
            end
            ROT_CW:
            begin
                sx = PORTRAIT_HEIGHT - 1 - py;
                sy = px;
            end
            ROT_INVERTED:
            begin
                sx = PORTRAIT_WIDTH - 1 - px;
                sy = PORTRAIT_HEIGHT - 1 - py;
            end
            default:
            begin
                sx = py;
                sy = PORTRAIT_WIDTH - 1 - px;
            end
        endcase
        p.sx = sx[COORD_W-1:0];
        p.sy = sy[COORD_W-1:0];
        p.ok = 1'b1;
        return p;
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_X_RAW_MIN: cal_x_lo = val;
            REG_X_RAW_MAX: cal_x_hi = val;
            REG_Y_RAW_MIN: cal_y_lo = val;
            REG_Y_RAW_MAX: cal_y_hi = val;
            REG_SWAP_AXES: swap_xy  = val[0];
            REG_INVERT_X:  mirror_x = val[0];
            REG_INVERT_Y:  mirror_y = val[0];
            default:       rot_sel  = rot_t'(val[1:0]);
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        while (raw_pending.size() != 0 || s_tvalid || points_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic pick_cal(output logic [15:0] lo, output logic [15:0] hi);
        int unsigned kind;
        kind = $urandom_range(9, 0);
        if (kind == 0)
        begin
            lo = 16'd0;
            hi = 16'hFFFF;
        end
        else if (kind == 1)
        begin
            lo = 16'($urandom);
            hi = 16'($urandom_range(lo, 0));
        end
        else if (kind == 2)
        begin
            lo = 16'($urandom_range(65534, 0));
            hi = lo + 16'($urandom_range((65535 - lo) < 16 ? (65535 - lo) : 16, 1));
        end
        else
        begin
            lo = 16'($urandom_range(32000, 0));
            hi = 16'($urandom_range(65535, lo + 1));
        end
    endtask

    function automatic logic [15:0] pick_raw(logic [15:0] lo, logic [15:0] hi);
        int unsigned r;
        r = $urandom_range(9, 0);
        case (r)
            0, 1: return 16'($urandom);
            2:    return $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
            3:    return lo;
            4:    return hi;
            default:
                return (lo < hi) ? 16'($urandom_range(hi, lo)) : 16'($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                points_due.push_back(map_point(s_tdata[15:0], s_tdata[31:16]));
            if (!s_tvalid || s_tready)
            begin
                if (raw_pending.size() != 0 && (steady || $urandom_range(99, 0) >= 25))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= raw_pending.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_seen <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_kick != hold_seen)
        begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (points_due.size() == 0)
                begin
                    $error("unexpected beat: screen_x %0d screen_y %0d mapped_ok %0d",
                           m_tdata[10:0], m_tdata[21:11], m_tuser[0]);
                    errors++;
                end
                else
                begin
                    want_pt = points_due.pop_front();
                    if (m_tdata[10:0] !== want_pt.sx)
                    begin
                        $error("screen_x: expected %0d, got %0d", want_pt.sx, m_tdata[10:0]);
                        errors++;
                    end
                    if (m_tdata[21:11] !== want_pt.sy)
                    begin
                        $error("screen_y: expected %0d, got %0d", want_pt.sy, m_tdata[21:11]);
                        errors++;
                    end
                    if (m_tuser[0] !== want_pt.ok)
                    begin
                        $error("mapped_ok: expected %0d, got %0d", want_pt.ok, m_tuser[0]);
                        errors++;
                    end
                end
            end
            m_tready <= (hold_left == 0) && (steady || $urandom_range(99, 0) >= 25);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_touch_coordinate_mapper NOT OK");
            $finish;
        end
    end

    initial
    begin
        int unsigned n;
        logic [15:0] lo, hi;

        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        cal_x_lo  = 16'd0;
        cal_x_hi  = 16'd4095;
        cal_y_lo  = 16'd0;
        cal_y_hi  = 16'd4095;
        swap_xy   = 1'b0;
        mirror_x  = 1'b0;
        mirror_y  = 1'b0;
        rot_sel   = ROT_PORTRAIT;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        raw_pending.push_back({16'd0, 16'd0});
        raw_pending.push_back({16'd4095, 16'd4095});
        raw_pending.push_back({16'hFFFF, 16'hFFFF});
        raw_pending.push_back({16'hFFFF, 16'd0});
        raw_pending.push_back({16'd0, 16'hFFFF});
        raw_pending.push_back({16'd3000, 16'd1234});
        wait_idle();

        write_reg(REG_X_RAW_MIN, 16'd0);
        write_reg(REG_X_RAW_MAX, 16'hFFFF);
        write_reg(REG_Y_RAW_MIN, 16'hFFFE);
        write_reg(REG_Y_RAW_MAX, 16'hFFFF);
        for (int r = 0; r < 4; r++)
        begin
            write_reg(REG_ROTATION, 16'(r));
            write_reg(REG_SWAP_AXES, 16'(r & 1));
            write_reg(REG_INVERT_X, 16'(r >> 1));
            write_reg(REG_INVERT_Y, 16'((r & 1) ^ (r >> 1)));
            raw_pending.push_back({16'hFFFE, 16'd0});
            raw_pending.push_back({16'hFFFF, 16'hFFFF});
            raw_pending.push_back({16'($urandom), 16'($urandom)});
            wait_idle();
        end

        write_reg(REG_X_RAW_MIN, 16'd777);
        write_reg(REG_X_RAW_MAX, 16'd777);
        raw_pending.push_back({16'd500, 16'd777});
        raw_pending.push_back({16'hFFFF, 16'hFFFF});
        wait_idle();
        write_reg(REG_X_RAW_MIN, 16'd0);
        write_reg(REG_X_RAW_MAX, 16'hFFFF);
        write_reg(REG_Y_RAW_MIN, 16'd40000);
        write_reg(REG_Y_RAW_MAX, 16'd100);
        raw_pending.push_back({16'd40000, 16'd100});
        raw_pending.push_back({16'd0, 16'hFFFF});
        wait_idle();

        for (int ph = 0; ph < 11; ph++)
        begin
            pick_cal(lo, hi);
            write_reg(REG_X_RAW_MIN, lo);
            write_reg(REG_X_RAW_MAX, hi);
            pick_cal(lo, hi);
            write_reg(REG_Y_RAW_MIN, lo);
            write_reg(REG_Y_RAW_MAX, hi);
            write_reg(REG_SWAP_AXES, 16'($urandom));
            write_reg(REG_INVERT_X, 16'($urandom));
            write_reg(REG_INVERT_Y, 16'($urandom));
            write_reg(REG_ROTATION, 16'($urandom));
            steady = (ph == 3);
            n = $urandom_range(75, 45);
            if (ph == 6)
            begin
                @(posedge clk);
                hold_kick <= ~hold_kick;
                n = 120;
            end
            repeat (n)
                raw_pending.push_back({pick_raw(cal_y_lo, cal_y_hi),
                                       pick_raw(cal_x_lo, cal_x_hi)});
            wait_idle();
        end
        steady = 1'b0;

        if (errors == 0)
            $display("tb_touch_coordinate_mapper OK");
        else
            $display("tb_touch_coordinate_mapper NOT OK");
        $finish;
    end

endmodule
